### sv/key_press_long_repeat_fsm_assert.svh
// Assertion macros used by the key press classifier checker.
`ifndef KEY_PRESS_LONG_REPEAT_FSM_ASSERT_SVH
`define KEY_PRESS_LONG_REPEAT_FSM_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define KPLR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("key press classifier assertion failed");

// Next-cycle implication, disabled while reset is high.
`define KPLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("key press classifier assertion failed");

`endif

### sv/kplr_pkg.sv
// Types, codes and constants of the key press classifier.
`default_nettype none

package kplr_pkg;

  localparam int TICK_WIDTH_DEF = 16;
  localparam int CODE_W         = 8;
  localparam int TICKS_W        = 8;
  localparam int CFG_TICK_W     = 16;
  localparam int SPEED_W        = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CODE_W-1:0]     PRESS_CODE_RST   = 8'd1;
  localparam logic [CODE_W-1:0]     RELEASE_CODE_RST = 8'd0;
  localparam logic [CFG_TICK_W-1:0] LONG_TICKS_RST   = 16'd1000;
  localparam logic [CFG_TICK_W-1:0] REPEAT_TICKS_RST = 16'd200;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd1,
    PH_PRESSED = 2'd2,
    PH_LONG    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_REPEAT = 2'd3
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESS_CODE   = 2'd0,
    REG_RELEASE_CODE = 2'd1,
    REG_LONG_TICKS   = 2'd2,
    REG_REPEAT_TICKS = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CODE_W-1:0]     press_code;
    logic [CODE_W-1:0]     release_code;
    logic [CFG_TICK_W-1:0] long_press_ticks;
    logic [CFG_TICK_W-1:0] repeat_ticks;
  } cfg_t;

endpackage

`default_nettype wire

### sv/key_press_long_repeat_fsm.sv
// Top level of the key press classifier: input register, step logic, result register.
`default_nettype none

// Key press classifier with short press, long press and accelerating repeat.
// Each input item is one poll of a key: the sampled key code and the timer
// ticks since the previous poll. Every item gives exactly one result item,
// key_event: none, short press, long press start or repeat.
// Both channels use valid/ready. An accepted item sits in an input register
// until the step logic evaluates it against the phase, hold counter
// and speedup state; the event lands in the result register at the edge of
// that step, which comes once the result register is free or being emptied.
// One item per cycle is sustained while the receiver does not stall, since
// the state update is one short compare-and-add path.
// When the receiver stalls, the result register holds its item, the input
// register keeps the next one, and in_ready drops only once both are full.
// The configuration port writes one register per cycle with no wait; it is
// meant to be used only while no item is in flight.
// Synchronous reset empties both registers, returns the phase to idle, clears
// the hold counter and speedup, and restores the register defaults (press code
// 1, release code 0, long press 1000 ticks, repeat period 200 ticks).
module key_press_long_repeat_fsm #(
  parameter int TICK_WIDTH = kplr_pkg::TICK_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [kplr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kplr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kplr_pkg::CODE_W-1:0]     key_sample,
  input  logic [kplr_pkg::TICKS_W-1:0]    ticks_elapsed,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      key_event
);
  import kplr_pkg::*;

  cfg_t                cfg;
  logic                in_full;
  logic [CODE_W-1:0]   key_q;
  logic [TICKS_W-1:0]  ticks_q;
  logic                step;
  event_t              step_event;

  // The held item is evaluated whenever the result register is free or
  // being emptied in this same cycle.
  assign step     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || step;

  kplr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kplr_fsm #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_fsm (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .key_sample    (key_q),
    .ticks_elapsed (ticks_q),
    .cfg           (cfg),
    .key_event     (step_event)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_q   <= key_sample;
      ticks_q <= ticks_elapsed;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      key_event <= step_event;
    end
  end

endmodule

`default_nettype wire

### sv/kplr_cfg.sv
// Configuration register file of the key press classifier.
`default_nettype none

module kplr_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [kplr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kplr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output kplr_pkg::cfg_t                   cfg
);
  import kplr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_code       <= PRESS_CODE_RST;
      cfg.release_code     <= RELEASE_CODE_RST;
      cfg.long_press_ticks <= LONG_TICKS_RST;
      cfg.repeat_ticks     <= REPEAT_TICKS_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PRESS_CODE:   cfg.press_code       <= cfg_data[CODE_W-1:0];
        REG_RELEASE_CODE: cfg.release_code     <= cfg_data[CODE_W-1:0];
        REG_LONG_TICKS:   cfg.long_press_ticks <= cfg_data[CFG_TICK_W-1:0];
        REG_REPEAT_TICKS: cfg.repeat_ticks     <= cfg_data[CFG_TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/kplr_fsm.sv
// Phase, hold counter and repeat speedup state with the per-poll step logic.
`default_nettype none

module kplr_fsm #(
  parameter int TICK_WIDTH = kplr_pkg::TICK_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [kplr_pkg::CODE_W-1:0]   key_sample,
  input  logic [kplr_pkg::TICKS_W-1:0]  ticks_elapsed,
  input  kplr_pkg::cfg_t                cfg,
  output kplr_pkg::event_t              key_event
);
  import kplr_pkg::*;

  localparam int CMP_W = (TICK_WIDTH > CFG_TICK_W) ? TICK_WIDTH : CFG_TICK_W;

  phase_t               phase, phase_next;
  logic [TICK_WIDTH-1:0] hold_count, hold_count_next;
  logic [SPEED_W-1:0]   speedup, speedup_next;

  logic [TICK_WIDTH:0]   hold_sum;
  logic [TICK_WIDTH-1:0] hold_acc;
  logic [CMP_W-1:0]      hold_ext;
  logic [SPEED_W-1:0]    thr;
  logic [SPEED_W:0]      speed_inc;
  logic                  is_press, is_release;
  logic                  long_hit, repeat_hit, speed_room;

  // Saturating accumulation of the elapsed ticks.
  assign hold_sum = {1'b0, hold_count}
                  + {{(TICK_WIDTH + 1 - TICKS_W){1'b0}}, ticks_elapsed};
  assign hold_acc = hold_sum[TICK_WIDTH] ? {TICK_WIDTH{1'b1}} : hold_sum[TICK_WIDTH-1:0];
  assign hold_ext = CMP_W'(hold_acc);

  assign is_press   = (key_sample == cfg.press_code);
  assign is_release = (key_sample == cfg.release_code);

  // Repeat period shrinks with speedup but never below one tick.
  always_comb begin
    thr = (cfg.repeat_ticks > speedup) ? (cfg.repeat_ticks - speedup) : '0;
    if (thr == '0) begin
      thr = SPEED_W'(1);
    end
  end

  assign speed_inc  = {1'b0, speedup} + (SPEED_W + 1)'(1);
  assign speed_room = (speed_inc < {1'b0, cfg.repeat_ticks});
  assign long_hit   = (hold_ext >= CMP_W'(cfg.long_press_ticks));
  assign repeat_hit = (hold_ext >= CMP_W'(thr));

  always_comb begin
    phase_next      = phase;
    hold_count_next = hold_acc;
    speedup_next    = speedup;
    key_event       = EV_NONE;
    case (phase)
      PH_IDLE: begin
        hold_count_next = '0;
        if (is_press) begin
          phase_next = PH_PRESSED;
        end
      end
      PH_PRESSED: begin
        if (is_release) begin
          phase_next      = PH_IDLE;
          hold_count_next = '0;
          key_event       = EV_SHORT;
        end else if (is_press) begin
          if (long_hit) begin
            phase_next      = PH_LONG;
            hold_count_next = '0;
            key_event       = EV_LONG;
          end
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_LONG: begin
        if (is_release) begin
          phase_next      = PH_IDLE;
          hold_count_next = '0;
          speedup_next    = '0;
        end else if (is_press) begin
          if (repeat_hit) begin
            if (speed_room) begin
              speedup_next = speed_inc[SPEED_W-1:0];
            end
            hold_count_next = '0;
            key_event       = EV_REPEAT;
          end
        end else begin
          phase_next = PH_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hold_count <= '0;
      speedup    <= '0;
    end else if (step) begin
      phase      <= phase_next;
      hold_count <= hold_count_next;
      speedup    <= speedup_next;
    end
  end

endmodule

`default_nettype wire

### sv/kplr_checker.sv
// Port-level checker for the key press classifier, with its bind statement.
`default_nettype none

`include "key_press_long_repeat_fsm_assert.svh"

module kplr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] key_event
);

  // A stalled result keeps its value.
  `KPLR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(key_event))

  // Input back-pressure only appears when a result is waiting and stalled.
  `KPLR_ASSERT_NOW(a_ready_only_on_stall, clk, rst, !in_ready, out_valid && !out_ready)

  // out_valid must be high once an accepted item has had time to pass the input and result registers.
  `KPLR_ASSERT_NEXT(a_result_latency, clk, rst, in_valid && in_ready, ##1 out_valid)

endmodule

bind key_press_long_repeat_fsm kplr_checker u_kplr_checker (.*);

`default_nettype wire

### sim/tb_key_press_long_repeat_fsm.sv
// Self-checking testbench for the key press classifier: directed polls, random hold episodes, then a saturation run.
`timescale 1ns / 100ps

module tb_key_press_long_repeat_fsm;
  import kplr_pkg::*;

  // The block runs at its default counter width; the predictor follows it.
  localparam int TICK_W = TICK_WIDTH_DEF;
  localparam logic [TICK_W:0] HOLD_MAX = {1'b0, {TICK_W{1'b1}}};

  // Cycle limit, far above the slowest correct run (about 500 items at 82% idling).
  localparam int CYCLE_LIMIT = 300000;
  // Cycles allowed after the last result of each phase.
  localparam int DRAIN_CYCLES = 8;
  // Only the first mismatches are printed; all of them are counted.
  localparam int MAX_PRINTED = 20;

  // One poll of the key, as it travels on the input channel.
  typedef struct packed {
    logic [CODE_W-1:0]  key;
    logic [TICKS_W-1:0] ticks;
  } poll_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CODE_W-1:0]     key_sample = '0;
  logic [TICKS_W-1:0]    ticks_elapsed = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            key_event;

  // Polls waiting to be driven, and the event each accepted poll should produce.
  poll_t  pending_polls[$];
  event_t expected_events[$];

  // Predictor state: our own copy of the registers and of the classifier.
  cfg_t                cur_cfg;
  phase_t              cls_phase;
  logic [TICK_W-1:0]   cls_hold;
  logic [SPEED_W-1:0]  cls_speedup;

  // Idling percentages for the current phase of the run.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int polls_queued = 0;
  int polls_accepted = 0;
  int results_checked = 0;
  int error_count = 0;
  int phase_count = 0;
  int cycle_count = 0;
  int ev_seen[4] = '{0, 0, 0, 0};

  poll_t drv_next;
  logic  drv_load;
  event_t mon_expected;

  key_press_long_repeat_fsm #(
    .TICK_WIDTH(TICK_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .key_sample   (key_sample),
    .ticks_elapsed(ticks_elapsed),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .key_event    (key_event)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predicts the event for one poll and advances the predictor state.
  // The elapsed ticks are added first, with saturation, then the key is judged.
  function automatic event_t classify_poll(input logic [CODE_W-1:0] key,
                                           input logic [TICKS_W-1:0] dt);
    logic [TICK_W:0] sum;
    longint unsigned thr;
    event_t ev;
    ev = EV_NONE;
    sum = {1'b0, cls_hold} + dt;
    cls_hold = (sum > HOLD_MAX) ? HOLD_MAX[TICK_W-1:0] : sum[TICK_W-1:0];
    case (cls_phase)
      PH_IDLE: begin
        // In idle a code equal to both press and release counts as a press.
        if (key == cur_cfg.press_code) cls_phase = PH_PRESSED;
        cls_hold = '0;
      end
      PH_PRESSED: begin
        if (key == cur_cfg.release_code) begin
          cls_phase = PH_IDLE;
          cls_hold = '0;
          ev = EV_SHORT;
        end else if (key == cur_cfg.press_code) begin
          if (longint'(cls_hold) >= longint'(cur_cfg.long_press_ticks)) begin
            cls_phase = PH_LONG;
            cls_hold = '0;
            ev = EV_LONG;
          end
        end else begin
          // Unknown code: back to idle, counter kept.
          cls_phase = PH_IDLE;
        end
      end
      PH_LONG: begin
        if (key == cur_cfg.release_code) begin
          cls_phase = PH_IDLE;
          cls_hold = '0;
          cls_speedup = '0;
        end else if (key == cur_cfg.press_code) begin
          // The repeat period shrinks with speedup but never drops below one tick.
          thr = (longint'(cur_cfg.repeat_ticks) > longint'(cls_speedup)) ?
                longint'(cur_cfg.repeat_ticks) - longint'(cls_speedup) : 0;
          if (thr < 1) thr = 1;
          if (longint'(cls_hold) >= thr) begin
            if (longint'(cls_speedup) + 1 < longint'(cur_cfg.repeat_ticks))
              cls_speedup = cls_speedup + 1'b1;
            cls_hold = '0;
            ev = EV_REPEAT;
          end
        end else begin
          // Unknown code: back to idle, counter and speedup kept.
          cls_phase = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
    return ev;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Driver: the predictor runs on each accepted item, then the next item is
  // presented unless the sender idles in this cycle or no poll is waiting.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_events.push_back(classify_poll(key_sample, ticks_elapsed));
        polls_accepted++;
      end
      if (!in_valid || in_ready) begin
        drv_load = (pending_polls.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        if (drv_load) begin
          drv_next = pending_polls.pop_front();
          key_sample <= drv_next.key;
          ticks_elapsed <= drv_next.ticks;
        end
        in_valid <= drv_load;
      end
    end
  end

  // Monitor: every accepted result is matched against the oldest expected event.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("result item %0d with no poll waiting", key_event));
        end else begin
          mon_expected = expected_events.pop_front();
          results_checked++;
          ev_seen[mon_expected]++;
          if (key_event !== mon_expected)
            report_mismatch($sformatf("result %0d: key_event %0d, expected %0d",
                                      results_checked, key_event, mon_expected));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles: %0d polls accepted, %0d results checked",
               cycle_count, polls_accepted, results_checked);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_poll(input logic [CODE_W-1:0] key, input logic [TICKS_W-1:0] ticks);
    poll_t p;
    p.key = key;
    p.ticks = ticks;
    pending_polls.push_back(p);
    polls_queued++;
  endtask

  // Drives one register write from the next edge on; the predictor copy is updated at once.
  // Code registers get random upper data bits, which the block must ignore.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    logic [CFG_DATA_W-1:0] data;
    data = val;
    if (idx == REG_PRESS_CODE || idx == REG_RELEASE_CODE)
      data[CFG_DATA_W-1:CODE_W] = (CFG_DATA_W-CODE_W)'($urandom);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_PRESS_CODE:   cur_cfg.press_code = val[CODE_W-1:0];
      REG_RELEASE_CODE: cur_cfg.release_code = val[CODE_W-1:0];
      REG_LONG_TICKS:   cur_cfg.long_press_ticks = val;
      REG_REPEAT_TICKS: cur_cfg.repeat_ticks = val;
      default: begin
      end
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_config(input logic [CODE_W-1:0] press, input logic [CODE_W-1:0] rel,
                            input logic [CFG_TICK_W-1:0] long_t,
                            input logic [CFG_TICK_W-1:0] rep_t);
    write_reg(REG_PRESS_CODE, {{(CFG_DATA_W-CODE_W){1'b0}}, press});
    write_reg(REG_RELEASE_CODE, {{(CFG_DATA_W-CODE_W){1'b0}}, rel});
    write_reg(REG_LONG_TICKS, long_t);
    write_reg(REG_REPEAT_TICKS, rep_t);
    end_writes();
  endtask

  // Lets the queued polls through with the given idling and waits until every
  // accepted poll has its result. Counters, not valid, tell when all is done.
  task automatic run_polls(input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    phase_count++;
    while (polls_accepted != polls_queued || expected_events.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [TICKS_W-1:0] random_ticks();
    logic [TICKS_W-1:0] t;
    case ($urandom_range(3))
      0: t = TICKS_W'($urandom_range(255));
      1: t = TICKS_W'($urandom_range(7));
      2: t = 8'hFF;
      default: t = TICKS_W'($urandom_range(64));
    endcase
    return t;
  endfunction

  // A key code that is neither the press nor the release code.
  function automatic logic [CODE_W-1:0] unknown_code();
    logic [CODE_W-1:0] k;
    do k = CODE_W'($urandom_range(255));
    while (k == cur_cfg.press_code || k == cur_cfg.release_code);
    return k;
  endfunction

  // Mostly whole key episodes: a press, a hold of random length, then usually
  // a release and sometimes a stray code. The rest is random noise.
  task automatic push_random_polls(input int count);
    int added;
    int hold_len;
    int pick;
    added = 0;
    while (added < count) begin
      if ($urandom_range(99) < 85) begin
        push_poll(cur_cfg.press_code, random_ticks());
        hold_len = $urandom_range(1, 12);
        repeat (hold_len) push_poll(cur_cfg.press_code, random_ticks());
        added += hold_len + 1;
        pick = $urandom_range(99);
        if (pick < 65) begin
          push_poll(cur_cfg.release_code, random_ticks());
          added++;
        end else if (pick < 85) begin
          push_poll(unknown_code(), random_ticks());
          added++;
        end
      end else begin
        push_poll(CODE_W'($urandom_range(255)), random_ticks());
        added++;
      end
    end
  endtask

  int idle_mode[4] = '{0, 82, 0, 20};
  int stall_mode[4] = '{0, 0, 82, 20};
  logic [CODE_W-1:0] rnd_press;

  initial begin
    cur_cfg.press_code = PRESS_CODE_RST;
    cur_cfg.release_code = RELEASE_CODE_RST;
    cur_cfg.long_press_ticks = LONG_TICKS_RST;
    cur_cfg.repeat_ticks = REPEAT_TICKS_RST;
    cls_phase = PH_IDLE;
    cls_hold = '0;
    cls_speedup = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed polls on the reset settings: a stray code in idle, a short
    // press, a long press after four full polls, two repeats with the period
    // shrinking, then stray codes from the long and the pressed phase.
    push_poll(8'hFF, 8'hFF);
    push_poll(8'h01, 8'h00);
    push_poll(8'h00, 8'h00);
    push_poll(8'h01, 8'h00);
    repeat (4) push_poll(8'h01, 8'hFF);
    push_poll(8'h01, 8'd200);
    push_poll(8'h01, 8'd199);
    push_poll(8'h01, 8'd100);
    push_poll(8'h80, 8'h00);
    push_poll(8'h01, 8'h00);
    push_poll(8'h7F, 8'h00);
    run_polls(0, 0);

    // Press and release codes equal: a press in idle, a release when pressed.
    set_config(8'h5A, 8'h5A, 16'd0, 16'd20);
    push_poll(8'h5A, 8'h00);
    push_poll(8'h5A, 8'h03);
    run_polls(0, 0);

    // Zero long threshold gives the long press at once; eight repeats build up
    // the speedup, which is then left above a lowered repeat period.
    set_config(8'h01, 8'h00, 16'd0, 16'd20);
    push_poll(8'h01, 8'h00);
    push_poll(8'h01, 8'h00);
    repeat (8) push_poll(8'h01, 8'hFF);
    run_polls(0, 0);

    // The block stays in the long phase across this write; the period floors
    // at one tick, and a release then clears the speedup.
    write_reg(REG_REPEAT_TICKS, 16'd3);
    end_writes();
    push_poll(8'h01, 8'h00);
    push_poll(8'h01, 8'h01);
    push_poll(8'h00, 8'h00);
    run_polls(0, 0);

    // Random episodes under several settings, each idling mode in turn.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(8'hFF, 8'h00, 16'd0, 16'd1);
        1: set_config(8'h00, 8'hFF, 16'd300, 16'd40);
        2: set_config(8'h5A, 8'h5A, 16'd50, 16'd5);
        3: set_config(8'h80, 8'h7F, 16'd600, 16'hFFFF);
        default: begin
          rnd_press = CODE_W'($urandom_range(255));
          set_config(rnd_press, ($urandom_range(3) == 0) ? rnd_press : 8'($urandom_range(255)),
                     16'($urandom_range(400)), 16'($urandom_range(1, 60)));
        end
      endcase
      push_random_polls(16);
      run_polls(idle_mode[ph % 4], stall_mode[ph % 4]);
    end

    // Largest thresholds: the hold counter has to saturate before the long
    // press comes, one poll past the exact maximum so the clamp is used.
    set_config(8'hA5, 8'h3C, 16'hFFFF, 16'hFFFF);
    push_poll(8'hA5, 8'h00);
    push_poll(8'hA5, 8'd254);
    repeat (257) push_poll(8'hA5, 8'hFF);
    push_poll(8'h3C, 8'hFF);
    run_polls(20, 20);

    $display("Run covered %0d polls in %0d phases, %0d results checked",
             polls_accepted, phase_count, results_checked);
    $display("Events seen: none %0d, short %0d, long %0d, repeat %0d",
             ev_seen[EV_NONE], ev_seen[EV_SHORT], ev_seen[EV_LONG], ev_seen[EV_REPEAT]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/kplr_pkg.sv
sv/kplr_cfg.sv
sv/kplr_fsm.sv
sv/key_press_long_repeat_fsm.sv
sv/kplr_checker.sv
sim/tb_key_press_long_repeat_fsm.sv
